// File: design/oale_pkg.sv
// Package for the ordered array list engine.
// Holds action and status codes, the result record and reset constants.
// No dependencies.
`default_nettype none

package oale_pkg;

  localparam int unsigned DEPTH_DEF = 16;
  localparam int unsigned CNT_W     = 5;
  localparam int unsigned WORD_W    = 32;

  localparam logic [CNT_W-1:0] CAP_RESET = 5'd16;

  localparam logic [2:0] ACT_APPEND  = 3'd0;
  localparam logic [2:0] ACT_INSERT  = 3'd1;
  localparam logic [2:0] ACT_DELETE  = 3'd2;
  localparam logic [2:0] ACT_READ    = 3'd3;
  localparam logic [2:0] ACT_REVERSE = 3'd4;
  localparam logic [2:0] ACT_SORT    = 3'd5;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_POS  = 2'd2;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [CNT_W-1:0]  count;
    logic [WORD_W-1:0] data;
    logic [1:0]        status;
  } res_t;

endpackage

`default_nettype wire

// File: design/oale_ram.sv
// Entry store: single write port, single read port, registered read data.
// Read data holds while no read is issued. Uses oale_pkg.
`default_nettype none

module oale_ram #(
  parameter int unsigned DEPTH = oale_pkg::DEPTH_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic                        clk_i,
  input  wire logic                        we_i,
  input  wire logic [AW-1:0]               waddr_i,
  input  wire logic [oale_pkg::WORD_W-1:0] wdata_i,
  input  wire logic                        re_i,
  input  wire logic [AW-1:0]               raddr_i,
  output logic      [oale_pkg::WORD_W-1:0] rdata_o
);
  import oale_pkg::*;

  logic [WORD_W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: design/oale_ctrl.sv
// Sequencer: decodes each request, walks the entry store through the RAM
// ports and builds the result record. Uses oale_pkg; drives oale_ram.
`default_nettype none

module oale_ctrl #(
  parameter int unsigned DEPTH = oale_pkg::DEPTH_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [2:0]                  in_action_i,
  input  wire logic [oale_pkg::CNT_W-1:0]  in_position_i,
  input  wire logic [oale_pkg::WORD_W-1:0] in_value_i,
  input  wire logic [oale_pkg::CNT_W-1:0]  cap_i,
  output logic                             res_valid_o,
  input  wire logic                        res_ready_i,
  output oale_pkg::res_t                   res_o,
  output logic                             mem_we_o,
  output logic      [AW-1:0]               mem_waddr_o,
  output logic      [oale_pkg::WORD_W-1:0] mem_wdata_o,
  output logic                             mem_re_o,
  output logic      [AW-1:0]               mem_raddr_o,
  input  wire logic [oale_pkg::WORD_W-1:0] mem_rdata_i
);
  import oale_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SWEEP = 3'd1;
  localparam logic [2:0] S_FIN   = 3'd2;
  localparam logic [2:0] S_REV   = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]        state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [2:0]        act_q, act_d;
  logic [CNT_W-1:0]  pos_q, pos_d;
  logic [WORD_W-1:0] val_q, val_d;
  logic [1:0]        status_q, status_d;
  logic [WORD_W-1:0] data_q, data_d;
  logic [CNT_W-1:0]  src_q, src_d;
  logic [CNT_W-1:0]  rem_q, rem_d;
  logic              pend_q, pend_d;
  logic [CNT_W-1:0]  tag_q, tag_d;
  logic [CNT_W-1:0]  i_q, i_d;
  logic [CNT_W-1:0]  j_q, j_d;
  logic [1:0]        ph_q, ph_d;
  logic [WORD_W-1:0] cur_q, cur_d;

  logic [CNT_W-1:0] waddr, raddr;
  logic             is_full;

  assign is_full     = count_q >= cap_i;
  assign mem_waddr_o = AW'(waddr);
  assign mem_raddr_o = AW'(raddr);

  assign res_o.status = status_q;
  assign res_o.data   = data_q;
  assign res_o.count  = count_q;
  assign res_o.empty  = (count_q == '0);
  assign res_o.full   = is_full;

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    act_d    = act_q;
    pos_d    = pos_q;
    val_d    = val_q;
    status_d = status_q;
    data_d   = data_q;
    src_d    = src_q;
    rem_d    = rem_q;
    pend_d   = pend_q;
    tag_d    = tag_q;
    i_d      = i_q;
    j_d      = j_q;
    ph_d     = ph_q;
    cur_d    = cur_q;
    mem_we_o    = 1'b0;
    waddr       = '0;
    mem_wdata_o = '0;
    mem_re_o    = 1'b0;
    raddr       = '0;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          act_d    = in_action_i;
          pos_d    = in_position_i;
          val_d    = in_value_i;
          status_d = ST_OK;
          data_d   = '0;
          pend_d   = 1'b0;
          state_d  = S_DONE;
          unique case (in_action_i) inside
            ACT_APPEND: begin
              if (is_full) begin
                status_d = ST_FULL;
              end else begin
                mem_we_o    = 1'b1;
                waddr       = count_q;
                mem_wdata_o = in_value_i;
                count_d     = count_q + 1'b1;
              end
            end
            ACT_INSERT: begin
              if (is_full) begin
                status_d = ST_FULL;
              end else if (in_position_i == '0 ||
                           {1'b0, in_position_i} > ({1'b0, count_q} + 6'd1)) begin
                status_d = ST_POS;
              end else begin
                src_d   = count_q - 1'b1;
                rem_d   = count_q - in_position_i + 1'b1;
                state_d = S_SWEEP;
              end
            end
            ACT_DELETE, ACT_READ: begin
              if (in_position_i == '0 || in_position_i > count_q) begin
                status_d = ST_POS;
              end else begin
                src_d   = in_position_i - 1'b1;
                rem_d   = (in_action_i == ACT_DELETE) ?
                          count_q - in_position_i + 1'b1 : CNT_W'(1);
                state_d = S_SWEEP;
              end
            end
            ACT_REVERSE: begin
              if (count_q > CNT_W'(1)) begin
                i_d     = '0;
                j_d     = count_q - 1'b1;
                ph_d    = 2'd0;
                state_d = S_REV;
              end
            end
            ACT_SORT: begin
              if (count_q > CNT_W'(1)) begin
                i_d     = '0;
                src_d   = '0;
                rem_d   = count_q;
                state_d = S_SWEEP;
              end
            end
            default: ;
          endcase
        end
      end

      S_SWEEP: begin
        // issue one read per cycle, consume the previous one
        if (rem_q != '0) begin
          mem_re_o = 1'b1;
          raddr    = src_q;
          src_d    = (act_q == ACT_INSERT) ? src_q - 1'b1 : src_q + 1'b1;
          rem_d    = rem_q - 1'b1;
          pend_d   = 1'b1;
          tag_d    = src_q;
        end else begin
          pend_d = 1'b0;
        end
        if (pend_q) begin
          case (act_q)
            ACT_INSERT: begin
              mem_we_o    = 1'b1;
              waddr       = tag_q + 1'b1;
              mem_wdata_o = mem_rdata_i;
            end
            ACT_DELETE: begin
              if (tag_q == pos_q - 1'b1) begin
                data_d = mem_rdata_i;
              end else begin
                mem_we_o    = 1'b1;
                waddr       = tag_q - 1'b1;
                mem_wdata_o = mem_rdata_i;
              end
            end
            ACT_READ: begin
              data_d = mem_rdata_i;
            end
            ACT_SORT: begin
              if (tag_q == i_q) begin
                cur_d = mem_rdata_i;
              end else if ($signed(cur_q) < $signed(mem_rdata_i)) begin
                mem_we_o    = 1'b1;
                waddr       = tag_q;
                mem_wdata_o = cur_q;
                cur_d       = mem_rdata_i;
              end
            end
            default: ;
          endcase
        end
        if (rem_q == '0 && !pend_q) begin
          state_d = S_FIN;
        end
      end

      S_FIN: begin
        state_d = S_DONE;
        case (act_q)
          ACT_INSERT: begin
            mem_we_o    = 1'b1;
            waddr       = pos_q - 1'b1;
            mem_wdata_o = val_q;
            count_d     = count_q + 1'b1;
          end
          ACT_DELETE: begin
            count_d = count_q - 1'b1;
          end
          ACT_SORT: begin
            mem_we_o    = 1'b1;
            waddr       = i_q;
            mem_wdata_o = cur_q;
            if (({1'b0, i_q} + 6'd2) < {1'b0, count_q}) begin
              i_d     = i_q + 1'b1;
              src_d   = i_q + 1'b1;
              rem_d   = count_q - i_q - 1'b1;
              state_d = S_SWEEP;
            end
          end
          default: ;
        endcase
      end

      S_REV: begin
        case (ph_q)
          2'd0: begin
            mem_re_o = 1'b1;
            raddr    = i_q;
            ph_d     = 2'd1;
          end
          2'd1: begin
            mem_re_o = 1'b1;
            raddr    = j_q;
            cur_d    = mem_rdata_i;
            ph_d     = 2'd2;
          end
          2'd2: begin
            mem_we_o    = 1'b1;
            waddr       = i_q;
            mem_wdata_o = mem_rdata_i;
            ph_d        = 2'd3;
          end
          default: begin
            mem_we_o    = 1'b1;
            waddr       = j_q;
            mem_wdata_o = cur_q;
            i_d         = i_q + 1'b1;
            j_d         = j_q - 1'b1;
            ph_d        = 2'd0;
            if (({1'b0, i_q} + 6'd2) >= {1'b0, j_q}) begin
              state_d = S_DONE;
            end
          end
        endcase
      end

      S_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q    <= act_d;
    pos_q    <= pos_d;
    val_q    <= val_d;
    status_q <= status_d;
    data_q   <= data_d;
    src_q    <= src_d;
    rem_q    <= rem_d;
    tag_q    <= tag_d;
    i_q      <= i_d;
    j_q      <= j_d;
    ph_q     <= ph_d;
    cur_q    <= cur_d;
  end

endmodule

`default_nettype wire

// File: design/ordered_array_list_engine_top.sv
// Ordered array list engine, top level: capacity register, output register,
// sequencer and entry store. Uses oale_pkg, oale_ctrl and oale_ram.
//
// Usage: each request on the slave stream carries an action, a 1-based
// position and a word; each request yields exactly one result on the master
// stream (status, data word, new count, empty and full flags).
// Capacity is written through cfg_we_i / cfg_wdata_i; the user must write it only while
// the block is idle, which the block itself does not enforce; it saturates at DEPTH.
// Work per request (n = count, p = position), all through the one-read,
// one-write entry RAM:
//   append, failed requests, unused actions: answered from idle without a walk
//   read: one entry; insert, delete: entries p to n each moved by one place
//   reverse: each pair read and swapped
//   sort: n - 1 passes, each sweeping the remaining tail of the list
// One request is in work at a time. A finished result moves into the output
// register, so the next request is taken while that result waits; a stalled
// receiver holds the result and, once the sequencer has another one done,
// halts further requests.
// Reset clears the count (empty list) and sets capacity to 16; the entry RAM
// is not cleared, entries are read only after being written.
`default_nettype none

module ordered_array_list_engine_top #(
  parameter int unsigned DEPTH = oale_pkg::DEPTH_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,  // action[2:0], position[7:3], value_in[39:8]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [47:0] m_axis_tdata,  // status[1:0], data_out[33:2], count_now[38:34],
                                          // is_empty_flag[39], is_full_flag[40], zero[47:41]
  input  wire logic        cfg_we_i,
  input  wire logic [4:0]  cfg_wdata_i
);
  import oale_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);

  logic [CNT_W-1:0]  cap_cfg_q;
  logic [CNT_W-1:0]  cap_eff;
  logic              res_valid, res_ready;
  res_t              res;
  logic              out_valid_q;
  res_t              out_q;
  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [WORD_W-1:0] mem_wdata, mem_rdata;

  assign cap_eff = (32'(cap_cfg_q) > DEPTH) ? CNT_W'(DEPTH) : cap_cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_cfg_q <= CAP_RESET;
    end else if (cfg_we_i) begin
      cap_cfg_q <= cfg_wdata_i;
    end
  end

  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_q};

  oale_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .in_action_i   (s_axis_tdata[2:0]),
    .in_position_i (s_axis_tdata[7:3]),
    .in_value_i    (s_axis_tdata[39:8]),
    .cap_i         (cap_eff),
    .res_valid_o   (res_valid),
    .res_ready_i   (res_ready),
    .res_o         (res),
    .mem_we_o      (mem_we),
    .mem_waddr_o   (mem_waddr),
    .mem_wdata_o   (mem_wdata),
    .mem_re_o      (mem_re),
    .mem_raddr_o   (mem_raddr),
    .mem_rdata_i   (mem_rdata)
  );

  oale_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule

`default_nettype wire
